>>> hdl/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

    // result kinds
    typedef enum logic [2:0] {
        K_KEY     = 3'd0,
        K_VALUE   = 3'd1,
        K_PAIR    = 3'd2,
        K_EOF     = 3'd3,
        K_ERROR   = 3'd4,
        K_FIN_OK  = 3'd5,
        K_FIN_ERR = 3'd6
    } t_kind;

    // parser states, one-hot
    typedef enum logic [11:0] {
        PS_BEFORE_KEY   = 12'b0000_0000_0001,
        PS_KEY          = 12'b0000_0000_0010,
        PS_AFTER_KEY    = 12'b0000_0000_0100,
        PS_BEFORE_VALUE = 12'b0000_0000_1000,
        PS_VALUE        = 12'b0000_0001_0000,
        PS_QKEY         = 12'b0000_0010_0000,
        PS_QVALUE       = 12'b0000_0100_0000,
        PS_QKEY_ESC     = 12'b0000_1000_0000,
        PS_QVALUE_ESC   = 12'b0001_0000_0000,
        PS_AFTER_VALUE  = 12'b0010_0000_0000,
        PS_COMMENT      = 12'b0100_0000_0000,
        PS_SECTION      = 12'b1000_0000_0000
    } t_pstate;

    // characters
    localparam logic [7:0] C_TAB     = 8'h09;
    localparam logic [7:0] C_LF      = 8'h0A;
    localparam logic [7:0] C_CR      = 8'h0D;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_QUOTE   = 8'h22;
    localparam logic [7:0] C_HASH    = 8'h23;
    localparam logic [7:0] C_EQUAL   = 8'h3D;
    localparam logic [7:0] C_LBRACK  = 8'h5B;
    localparam logic [7:0] C_BSLASH  = 8'h5C;
    localparam logic [7:0] C_RBRACK  = 8'h5D;
    localparam logic [7:0] C_LOWER_A = 8'h61;
    localparam logic [7:0] C_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // stop words, element 0 is the first letter
    localparam logic [4:0][7:0] ERR_WORD = {8'h52, 8'h4F, 8'h52, 8'h52, 8'h45};
    localparam logic [2:0][7:0] EOF_WORD = {8'h46, 8'h4F, 8'h45};
    localparam logic [2:0]      ERR_LEN  = 3'd5;
    localparam logic [2:0]      EOF_LEN  = 3'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       finish;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic live;
        logic latch;
        logic emit_pair;
        logic emit_rep;
        logic emit_tail;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic slot_free;
        logic has_pair;
        logic has_replay;
        logic has_tail;
        logic rep_last;
    } t_status;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= C_LOWER_A && c <= C_LOWER_Z) begin
            return c - CASE_GAP;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/kvt_dp.sv
`default_nettype none

module kvt_dp #(
    parameter int SECTION_MAX = 32,
    parameter int LEN_W       = 6,
    parameter int IDX_W       = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kvt_pkg::t_in_item i_in_data,
    input  wire kvt_pkg::t_cmd     i_cmd,
    output kvt_pkg::t_status       o_status,
    output logic                   o_out_valid,
    output kvt_pkg::t_out_item     o_out_data,
    input  wire logic              i_out_ready
);

    typedef struct packed {
        logic [2:0] kpc;
        logic       eofm;
        logic       errm;
    } t_track;

    function automatic t_track f_track(input t_track s, input logic [7:0] u);
        t_track r;
        r = s;
        if (s.kpc < kvt_pkg::EOF_LEN && u != kvt_pkg::EOF_WORD[s.kpc[1:0]]) begin
            r.eofm = 1'b0;
        end
        if (s.kpc < kvt_pkg::ERR_LEN && u != kvt_pkg::ERR_WORD[s.kpc]) begin
            r.errm = 1'b0;
        end
        if (s.kpc < kvt_pkg::ERR_LEN) begin
            r.kpc = s.kpc + 3'd1;
        end
        return r;
    endfunction

    kvt_pkg::t_in_item  r_item;
    kvt_pkg::t_in_item  cur;
    kvt_pkg::t_pstate   r_ps, n_ps, eff;
    logic [LEN_W-1:0]   r_len, n_len;
    t_track             r_trk, n_trk, start_trk;
    logic               r_cut, n_cut;
    logic               r_halt, n_halt;
    logic [7:0]         r_sect [SECTION_MAX];
    logic [7:0]         r_rd;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               wr_en;
    logic               has_pair, has_rep_req, has_tail, has_replay, rep_last;
    kvt_pkg::t_kind     tail_kind;
    logic [7:0]         tail_byte;
    logic [7:0]         c, u;
    logic               fin, ws, pdelim;
    logic               r_ov;
    kvt_pkg::t_out_item r_out;

    assign cur = i_cmd.live ? i_in_data : r_item;
    assign c   = cur.text_byte;
    assign fin = cur.finish;
    assign u   = kvt_pkg::upcase(c);
    assign ws  = (c == kvt_pkg::C_SPACE) || (c == kvt_pkg::C_TAB);
    assign pdelim = ws || (c == kvt_pkg::C_CR) || (c == kvt_pkg::C_LF) ||
                    (c == kvt_pkg::C_HASH);

    always_comb begin
        start_trk.kpc  = 3'd0;
        start_trk.eofm = 1'b1;
        start_trk.errm = 1'b1;
    end

    always_comb begin
        has_pair    = 1'b0;
        has_rep_req = 1'b0;
        has_tail    = 1'b0;
        tail_kind   = kvt_pkg::K_KEY;
        tail_byte   = 8'd0;
        wr_en       = 1'b0;
        n_ps        = r_ps;
        n_len       = r_len;
        n_trk       = r_trk;
        n_cut       = r_cut;
        n_halt      = r_halt;
        eff         = r_ps;
        if (fin) begin
            has_pair = !r_halt && (r_ps == kvt_pkg::PS_AFTER_VALUE);
            has_tail = 1'b1;
            if (r_halt || r_ps == kvt_pkg::PS_BEFORE_KEY || r_ps == kvt_pkg::PS_COMMENT ||
                r_ps == kvt_pkg::PS_AFTER_VALUE) begin
                tail_kind = kvt_pkg::K_FIN_OK;
            end else begin
                tail_kind = kvt_pkg::K_FIN_ERR;
            end
            n_ps   = kvt_pkg::PS_BEFORE_KEY;
            n_len  = '0;
            n_trk  = start_trk;
            n_cut  = 1'b0;
            n_halt = 1'b0;
        end else if (!r_halt) begin
            // pair end first, then the byte is handled as in the before-key state
            has_pair = (r_ps == kvt_pkg::PS_AFTER_VALUE);
            if (has_pair) begin
                eff  = kvt_pkg::PS_BEFORE_KEY;
                n_ps = kvt_pkg::PS_BEFORE_KEY;
            end
            unique case (eff)
                kvt_pkg::PS_SECTION: begin
                    if (c == kvt_pkg::C_RBRACK) begin
                        n_ps = kvt_pkg::PS_BEFORE_KEY;
                    end else if (r_len < LEN_W'(SECTION_MAX)) begin
                        wr_en = 1'b1;
                        n_len = r_len + 1'b1;
                    end
                end
                kvt_pkg::PS_BEFORE_KEY: begin
                    if (c == kvt_pkg::C_LBRACK) begin
                        n_len = '0;
                        n_ps  = kvt_pkg::PS_SECTION;
                    end else if (c == kvt_pkg::C_EQUAL) begin
                        has_rep_req = 1'b1;
                        n_ps        = kvt_pkg::PS_BEFORE_VALUE;
                    end else if (c == kvt_pkg::C_HASH) begin
                        n_ps = kvt_pkg::PS_COMMENT;
                    end else if (ws || c == kvt_pkg::C_LF || c == kvt_pkg::C_CR) begin
                        n_ps = kvt_pkg::PS_BEFORE_KEY;
                    end else if (c == kvt_pkg::C_QUOTE) begin
                        has_rep_req = 1'b1;
                        n_ps        = kvt_pkg::PS_QKEY;
                    end else begin
                        has_rep_req = 1'b1;
                        has_tail    = 1'b1;
                        tail_byte   = u;
                        n_trk       = f_track(start_trk, u);
                        n_cut       = 1'b0;
                        n_ps        = kvt_pkg::PS_KEY;
                    end
                end
                kvt_pkg::PS_KEY: begin
                    if (c == kvt_pkg::C_LF) begin
                        if (r_trk.errm && r_trk.kpc >= kvt_pkg::ERR_LEN) begin
                            n_halt    = 1'b1;
                            has_tail  = 1'b1;
                            tail_kind = kvt_pkg::K_ERROR;
                        end else if (r_trk.eofm && r_trk.kpc >= kvt_pkg::EOF_LEN) begin
                            n_halt    = 1'b1;
                            has_tail  = 1'b1;
                            tail_kind = kvt_pkg::K_EOF;
                        end else begin
                            n_cut = 1'b1;
                        end
                    end else if (ws) begin
                        n_ps = kvt_pkg::PS_AFTER_KEY;
                    end else if (c == kvt_pkg::C_EQUAL) begin
                        n_ps = kvt_pkg::PS_BEFORE_VALUE;
                    end else if (!r_cut) begin
                        has_tail  = 1'b1;
                        tail_byte = u;
                        n_trk     = f_track(r_trk, u);
                    end
                end
                kvt_pkg::PS_AFTER_KEY: begin
                    if (c == kvt_pkg::C_EQUAL) begin
                        n_ps = kvt_pkg::PS_BEFORE_VALUE;
                    end
                end
                kvt_pkg::PS_BEFORE_VALUE: begin
                    if (c == kvt_pkg::C_QUOTE) begin
                        n_ps = kvt_pkg::PS_QVALUE;
                    end else if (!ws) begin
                        has_tail  = 1'b1;
                        tail_kind = kvt_pkg::K_VALUE;
                        tail_byte = c;
                        n_ps      = kvt_pkg::PS_VALUE;
                    end
                end
                kvt_pkg::PS_VALUE: begin
                    if (pdelim) begin
                        n_ps = kvt_pkg::PS_AFTER_VALUE;
                    end else begin
                        has_tail  = 1'b1;
                        tail_kind = kvt_pkg::K_VALUE;
                        tail_byte = c;
                    end
                end
                kvt_pkg::PS_QKEY: begin
                    if (c == kvt_pkg::C_QUOTE) begin
                        n_ps = kvt_pkg::PS_AFTER_KEY;
                    end else begin
                        has_tail  = 1'b1;
                        tail_byte = u;
                        if (c == kvt_pkg::C_BSLASH) begin
                            n_ps = kvt_pkg::PS_QKEY_ESC;
                        end
                    end
                end
                kvt_pkg::PS_QVALUE: begin
                    if (c == kvt_pkg::C_QUOTE) begin
                        n_ps = kvt_pkg::PS_AFTER_VALUE;
                    end else begin
                        has_tail  = 1'b1;
                        tail_kind = kvt_pkg::K_VALUE;
                        tail_byte = c;
                        if (c == kvt_pkg::C_BSLASH) begin
                            n_ps = kvt_pkg::PS_QVALUE_ESC;
                        end
                    end
                end
                kvt_pkg::PS_QKEY_ESC: begin
                    has_tail  = 1'b1;
                    tail_byte = u;
                    n_ps      = kvt_pkg::PS_QKEY;
                end
                kvt_pkg::PS_QVALUE_ESC: begin
                    has_tail  = 1'b1;
                    tail_kind = kvt_pkg::K_VALUE;
                    tail_byte = c;
                    n_ps      = kvt_pkg::PS_QVALUE;
                end
                kvt_pkg::PS_COMMENT: begin
                    if (c == kvt_pkg::C_LF) begin
                        n_ps = kvt_pkg::PS_BEFORE_KEY;
                    end
                end
                default: begin
                    n_ps = kvt_pkg::PS_BEFORE_KEY;
                end
            endcase
        end
    end

    assign has_replay = has_rep_req && (r_len != '0);
    assign rep_last   = (LEN_W'(r_idx) + 1'b1) == r_len;

    always_comb begin
        if (i_cmd.emit_rep) begin
            n_idx = rep_last ? '0 : r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    assign o_status.slot_free  = !r_ov || i_out_ready;
    assign o_status.has_pair   = has_pair;
    assign o_status.has_replay = has_replay;
    assign o_status.has_tail   = has_tail;
    assign o_status.rep_last   = rep_last;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps   <= kvt_pkg::PS_BEFORE_KEY;
            r_len  <= '0;
            r_trk  <= start_trk;
            r_cut  <= 1'b0;
            r_halt <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.commit) begin
                r_ps   <= n_ps;
                r_len  <= n_len;
                r_trk  <= n_trk;
                r_cut  <= n_cut;
                r_halt <= n_halt;
            end
        end
    end

    // section store, read address runs one step ahead of the replay index
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            r_sect[r_len[IDX_W-1:0]] <= c;
        end
        r_rd <= r_sect[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit_pair || i_cmd.emit_rep || i_cmd.emit_tail) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pair) begin
            r_out.kind     <= kvt_pkg::K_PAIR;
            r_out.out_byte <= 8'd0;
            r_out.last     <= !has_replay && !has_tail;
        end else if (i_cmd.emit_rep) begin
            r_out.kind     <= kvt_pkg::K_KEY;
            r_out.out_byte <= kvt_pkg::upcase(r_rd);
            r_out.last     <= rep_last && !has_tail;
        end else if (i_cmd.emit_tail) begin
            r_out.kind     <= tail_kind;
            r_out.out_byte <= tail_byte;
            r_out.last     <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> hdl/kvt_ctrl.sv
`default_nettype none

module kvt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire kvt_pkg::t_status i_status,
    output kvt_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REPLAY = 3'b010,
        ST_TAIL   = 3'b100
    } t_state;

    t_state r_st, n_st;

    always_comb begin
        o_cmd      = '0;
        n_st       = r_st;
        o_in_ready = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                o_cmd.live = 1'b1;
                o_in_ready = i_status.slot_free;
                if (i_in_valid && i_status.slot_free) begin
                    o_cmd.latch = 1'b1;
                    if (i_status.has_pair) begin
                        o_cmd.emit_pair = 1'b1;
                        if (i_status.has_replay) begin
                            n_st = ST_REPLAY;
                        end else if (i_status.has_tail) begin
                            n_st = ST_TAIL;
                        end else begin
                            o_cmd.commit = 1'b1;
                        end
                    end else if (i_status.has_replay) begin
                        n_st = ST_REPLAY;
                    end else begin
                        o_cmd.emit_tail = i_status.has_tail;
                        o_cmd.commit    = 1'b1;
                    end
                end
            end
            ST_REPLAY: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_rep = 1'b1;
                    if (i_status.rep_last) begin
                        if (i_status.has_tail) begin
                            n_st = ST_TAIL;
                        end else begin
                            o_cmd.commit = 1'b1;
                            n_st         = ST_IDLE;
                        end
                    end
                end
            end
            ST_TAIL: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_tail = 1'b1;
                    o_cmd.commit    = 1'b1;
                    n_st            = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

>>> hdl/key_value_text_tokenizer_core.sv
`default_nettype none

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+----------------------------
// input    | in        | i_in_valid / o_in_ready    | i_in_data  (text_byte, finish)
// output   | out       | o_out_valid / i_out_ready  | o_out_data (kind, out_byte, last)
//
// an item giving zero or one result is handled in its accept cycle; a key start that
// replays the section emits the section bytes one after another, then the key byte
// itself if there is one, read through the single read port of the section store
// a pending pair end ahead of other results rides in the accept cycle
// reset is synchronous, active low; the section store is not cleared
// input is taken only while the output register is empty or being drained

module key_value_text_tokenizer_core #(
    parameter int SECTION_MAX = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire kvt_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output kvt_pkg::t_out_item      o_out_data
);

    // section length counts up to SECTION_MAX, index addresses the store
    localparam int LEN_W = $clog2(SECTION_MAX + 1);
    localparam int IDX_W = (SECTION_MAX > 1) ? $clog2(SECTION_MAX) : 1;

    kvt_pkg::t_cmd    cmd;
    kvt_pkg::t_status status;

    // sequencer: decides which results of the current item go out, and when
    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // parser state, section store and output register
    kvt_dp #(
        .SECTION_MAX (SECTION_MAX),
        .LEN_W       (LEN_W),
        .IDX_W       (IDX_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule

`default_nettype wire

>>> hdl/kvt_checker.sv
`default_nettype none

module kvt_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire kvt_pkg::t_in_item  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire kvt_pkg::t_out_item o_out_data
);

    // a waiting input transfer holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_data)))
        else $error("waiting input changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // no input transfer while a result is stuck
    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while output blocked");

    // only key and value results carry a byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind != kvt_pkg::K_KEY &&
         o_out_data.kind != kvt_pkg::K_VALUE) |-> (o_out_data.out_byte == 8'd0))
        else $error("status result with nonzero byte");

    // stop and finish results close their item
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind == kvt_pkg::K_EOF ||
         o_out_data.kind == kvt_pkg::K_ERROR || o_out_data.kind == kvt_pkg::K_FIN_OK ||
         o_out_data.kind == kvt_pkg::K_FIN_ERR)) |-> o_out_data.last)
        else $error("status result without last");

endmodule

bind key_value_text_tokenizer_core kvt_checker u_kvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int SEC_MAX = 32;

    // stop words, first letter in the top byte
    localparam logic [39:0] ERR_TXT = "ERROR";
    localparam logic [23:0] EOF_TXT = "EOF";

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_TIGHT,
        RX_COMB
    } t_rx_mode;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    kvt_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    kvt_pkg::t_out_item out_data;

    key_value_text_tokenizer_core #(
        .SECTION_MAX(SEC_MAX)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    // parser mirror
    kvt_pkg::t_pstate ps    = kvt_pkg::PS_BEFORE_KEY;
    logic [7:0] sec_mem [SEC_MAX];
    int         sec_len   = 0;
    int         pfx_cnt   = 0;
    bit         eof_ok    = 1'b1;
    bit         err_ok    = 1'b1;
    bit         cut_off   = 1'b0;
    bit         halted_p  = 1'b0;

    kvt_pkg::t_out_item token_q [$];
    logic [7:0] txt_q [$];
    int         step_cnt  = 0;

    int err_cnt    = 0;
    int sent_cnt   = 0;
    int live_cnt   = 0;
    int rx_cnt     = 0;
    int stop_cnt   = 0;
    int fin_cnt    = 0;
    int burst_left = 0;

    task automatic flag_mismatch(input string what);
        err_cnt++;
        $display("mismatch @%0t: %s", $time, what);
    endtask

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? {c[7:6], 1'b0, c[4:0]} : c;
    endfunction

    task automatic add_token(input kvt_pkg::t_kind k, input logic [7:0] b);
        kvt_pkg::t_out_item r;
        r.kind     = k;
        r.out_byte = b;
        r.last     = 1'b0;
        token_q.push_back(r);
        step_cnt++;
    endtask

    task automatic replay_section();
        for (int i = 0; i < sec_len; i++) begin
            add_token(kvt_pkg::K_KEY, fold_upper(sec_mem[i]));
        end
    endtask

    // follow the key text against the two stop words
    task automatic note_prefix(input logic [7:0] c);
        if (pfx_cnt < 3) begin
            if (c != EOF_TXT[8*(2-pfx_cnt) +: 8]) eof_ok = 1'b0;
        end
        if (pfx_cnt < 5) begin
            if (c != ERR_TXT[8*(4-pfx_cnt) +: 8]) err_ok = 1'b0;
            pfx_cnt++;
        end
    endtask

    task automatic restart_parser();
        ps       = kvt_pkg::PS_BEFORE_KEY;
        sec_len  = 0;
        pfx_cnt  = 0;
        eof_ok   = 1'b1;
        err_ok   = 1'b1;
        cut_off  = 1'b0;
        halted_p = 1'b0;
    endtask

    function automatic bit is_blank(input logic [7:0] c);
        return c == kvt_pkg::C_SPACE || c == kvt_pkg::C_TAB;
    endfunction

    // expected tokens for one input transfer
    task automatic tokenize(input kvt_pkg::t_in_item it);
        logic [7:0]         c;
        bit                 again;
        kvt_pkg::t_out_item r;
        c        = it.text_byte;
        step_cnt = 0;
        if (it.finish) begin
            fin_cnt++;
            if (halted_p) begin
                add_token(kvt_pkg::K_FIN_OK, 8'h00);
            end else begin
                if (ps == kvt_pkg::PS_AFTER_VALUE) add_token(kvt_pkg::K_PAIR, 8'h00);
                if (ps == kvt_pkg::PS_BEFORE_KEY || ps == kvt_pkg::PS_COMMENT ||
                    ps == kvt_pkg::PS_AFTER_VALUE) begin
                    add_token(kvt_pkg::K_FIN_OK, 8'h00);
                end else begin
                    add_token(kvt_pkg::K_FIN_ERR, 8'h00);
                end
            end
            restart_parser();
        end else if (!halted_p) begin
            do begin
                again = 1'b0;
                case (ps)
                    kvt_pkg::PS_SECTION: begin
                        if (c == kvt_pkg::C_RBRACK) begin
                            ps = kvt_pkg::PS_BEFORE_KEY;
                        end else if (sec_len < SEC_MAX) begin
                            sec_mem[sec_len] = c;
                            sec_len++;
                        end
                    end
                    kvt_pkg::PS_BEFORE_KEY: begin
                        if (c == kvt_pkg::C_LBRACK) begin
                            sec_len = 0;
                            ps = kvt_pkg::PS_SECTION;
                        end else if (c == kvt_pkg::C_EQUAL) begin
                            replay_section();
                            ps = kvt_pkg::PS_BEFORE_VALUE;
                        end else if (c == kvt_pkg::C_HASH) begin
                            ps = kvt_pkg::PS_COMMENT;
                        end else if (is_blank(c) || c == kvt_pkg::C_LF ||
                                     c == kvt_pkg::C_CR) begin
                            // whitespace between pairs
                        end else if (c == kvt_pkg::C_QUOTE) begin
                            replay_section();
                            ps = kvt_pkg::PS_QKEY;
                        end else begin
                            replay_section();
                            add_token(kvt_pkg::K_KEY, fold_upper(c));
                            pfx_cnt = 0;
                            eof_ok  = 1'b1;
                            err_ok  = 1'b1;
                            cut_off = 1'b0;
                            note_prefix(fold_upper(c));
                            ps = kvt_pkg::PS_KEY;
                        end
                    end
                    kvt_pkg::PS_KEY: begin
                        if (c == kvt_pkg::C_LF) begin
                            if (err_ok && pfx_cnt >= 5) begin
                                halted_p = 1'b1;
                                stop_cnt++;
                                add_token(kvt_pkg::K_ERROR, 8'h00);
                            end else if (eof_ok && pfx_cnt >= 3) begin
                                halted_p = 1'b1;
                                stop_cnt++;
                                add_token(kvt_pkg::K_EOF, 8'h00);
                            end else begin
                                cut_off = 1'b1;
                            end
                        end else if (is_blank(c)) begin
                            ps = kvt_pkg::PS_AFTER_KEY;
                        end else if (c == kvt_pkg::C_EQUAL) begin
                            ps = kvt_pkg::PS_BEFORE_VALUE;
                        end else if (!cut_off) begin
                            add_token(kvt_pkg::K_KEY, fold_upper(c));
                            note_prefix(fold_upper(c));
                        end
                    end
                    kvt_pkg::PS_AFTER_KEY: begin
                        if (c == kvt_pkg::C_EQUAL) ps = kvt_pkg::PS_BEFORE_VALUE;
                    end
                    kvt_pkg::PS_BEFORE_VALUE: begin
                        if (is_blank(c)) begin
                            // leading blanks
                        end else if (c == kvt_pkg::C_QUOTE) begin
                            ps = kvt_pkg::PS_QVALUE;
                        end else begin
                            add_token(kvt_pkg::K_VALUE, c);
                            ps = kvt_pkg::PS_VALUE;
                        end
                    end
                    kvt_pkg::PS_VALUE: begin
                        if (is_blank(c) || c == kvt_pkg::C_CR || c == kvt_pkg::C_LF ||
                            c == kvt_pkg::C_HASH) begin
                            ps = kvt_pkg::PS_AFTER_VALUE;
                        end else begin
                            add_token(kvt_pkg::K_VALUE, c);
                        end
                    end
                    kvt_pkg::PS_QKEY: begin
                        if (c == kvt_pkg::C_QUOTE) begin
                            ps = kvt_pkg::PS_AFTER_KEY;
                        end else begin
                            add_token(kvt_pkg::K_KEY, fold_upper(c));
                            if (c == kvt_pkg::C_BSLASH) ps = kvt_pkg::PS_QKEY_ESC;
                        end
                    end
                    kvt_pkg::PS_QVALUE: begin
                        if (c == kvt_pkg::C_QUOTE) begin
                            ps = kvt_pkg::PS_AFTER_VALUE;
                        end else begin
                            add_token(kvt_pkg::K_VALUE, c);
                            if (c == kvt_pkg::C_BSLASH) ps = kvt_pkg::PS_QVALUE_ESC;
                        end
                    end
                    kvt_pkg::PS_QKEY_ESC: begin
                        add_token(kvt_pkg::K_KEY, fold_upper(c));
                        ps = kvt_pkg::PS_QKEY;
                    end
                    kvt_pkg::PS_QVALUE_ESC: begin
                        add_token(kvt_pkg::K_VALUE, c);
                        ps = kvt_pkg::PS_QVALUE;
                    end
                    kvt_pkg::PS_AFTER_VALUE: begin
                        // close the pair, then handle the byte again as in the before-key state
                        add_token(kvt_pkg::K_PAIR, 8'h00);
                        ps = kvt_pkg::PS_BEFORE_KEY;
                        again = 1'b1;
                    end
                    kvt_pkg::PS_COMMENT: begin
                        if (c == kvt_pkg::C_LF) ps = kvt_pkg::PS_BEFORE_KEY;
                    end
                    default: begin
                        ps = kvt_pkg::PS_BEFORE_KEY;
                    end
                endcase
            end while (again);
        end
        if (step_cnt > 0) begin
            r = token_q.pop_back();
            r.last = 1'b1;
            token_q.push_back(r);
        end
    endtask

    // one input transfer, with bursty idling ahead of it
    task automatic send_item(input logic [7:0] b, input logic fin);
        kvt_pkg::t_in_item it;
        int                gap;
        bit                took;
        bit                was_live;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        it.text_byte = b;
        it.finish    = fin;
        was_live     = !halted_p;
        tokenize(it);
        in_data  <= it;
        in_valid <= 1'b1;
        do begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
        sent_cnt++;
        if (was_live) live_cnt++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    // sender holds off until every pending token has come out
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (token_q.size() != 0);
    endtask

    // receiver stall pattern, switching mode every so often
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_OPEN:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
            RX_TIGHT: out_ready <= ($urandom_range(0, 4) == 0);
            default:  out_ready <= (rx_tick % 3 == 0);
        endcase
    end

    // checker: sample mid-cycle, the transfer lands on the next rising edge
    always @(negedge clk) begin
        kvt_pkg::t_out_item got;
        kvt_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            got = out_data;
            if (token_q.size() == 0) begin
                flag_mismatch($sformatf("token %0d (kind %0d byte %02h) not expected",
                                        rx_cnt, got.kind, got.out_byte));
            end else begin
                want = token_q.pop_front();
                if (got.kind !== want.kind)
                    flag_mismatch($sformatf("token %0d kind %0d, wanted %0d",
                                            rx_cnt, got.kind, want.kind));
                if (got.out_byte !== want.out_byte)
                    flag_mismatch($sformatf("token %0d byte %02h, wanted %02h",
                                            rx_cnt, got.out_byte, want.out_byte));
                if (got.last !== want.last)
                    flag_mismatch($sformatf("token %0d last %0b, wanted %0b",
                                            rx_cnt, got.last, want.last));
            end
            rx_cnt++;
        end
    end

    // ------------------------------------------------------------ directed

    task automatic test_plain_pairs();
        send_str("alpha=1\nBeta = two\tz=\n");
        send_str("x=y");
        send_item(kvt_pkg::C_CR, 1'b0);
        send_str("k=v#c\nnext");
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_quoted();
        send_str("\"a\\\"b\" = \"x\\\\y\\\"z\" ");
        send_str("q=\"\"");
        send_item(8'hFF, 1'b1);
        send_str("\"open");
        send_item(8'h41, 1'b1);
    endtask

    task automatic test_sections();
        send_str("[net]host=h1\n=empty\n[]k=v\n");
        send_str("[ab");
        send_item(8'h5A, 1'b1);
        hold_until_drained();
    endtask

    task automatic test_long_section();
        logic [7:0] b;
        send_item(kvt_pkg::C_LBRACK, 1'b0);
        for (int i = 0; i < 40; i++) begin
            b = 8'(i * 7);
            if (b == kvt_pkg::C_RBRACK) b = 8'h00;
            if (i == 39) b = 8'hFF;
            send_item(b, 1'b0);
        end
        // second key start after a value gives the widest burst of tokens
        send_str("]k=v\nq=1 ");
        send_item(8'h00, 1'b1);
        hold_until_drained();
    endtask

    task automatic test_key_newline();
        send_str("ab\ncd=v\nERR\nx=1\nk=\nzz ");
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_stops();
        send_str("ERROR\nzz=1\n");
        send_item(8'h00, 1'b1);
        send_str("eofile\nx=y");
        send_item(8'hFF, 1'b1);
    endtask

    task automatic test_finish_states();
        send_item(8'h00, 1'b1);
        send_str("#note");
        send_item(8'h00, 1'b1);
        send_str("k=v");
        send_item(8'h00, 1'b1);
        send_str("k =");
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(kvt_pkg::C_EQUAL, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(kvt_pkg::C_LF, 1'b0);
        send_item(8'hFF, 1'b1);
        hold_until_drained();
    endtask

    // ------------------------------------------------------------ random text

    task automatic put(input logic [7:0] b);
        txt_q.push_back(b);
    endtask

    task automatic flush_text();
        logic [7:0] b;
        while (txt_q.size() > 0) begin
            b = txt_q.pop_front();
            send_item(b, 1'b0);
        end
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        case ($urandom_range(0, 4))
            0:       c = 8'($urandom_range("a", "z"));
            1:       c = 8'($urandom_range("A", "Z"));
            2:       c = 8'($urandom_range("0", "9"));
            3:       c = "_";
            default: c = 8'($urandom_range("-", "/"));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0) return word_char();
        do begin
            c = 8'($urandom_range(0, 255));
        end while (is_blank(c) || c == kvt_pkg::C_CR || c == kvt_pkg::C_LF ||
                   c == kvt_pkg::C_HASH);
        return c;
    endfunction

    function automatic logic [7:0] byte_but(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == a || c == b);
        return c;
    endfunction

    task automatic put_blanks();
        repeat ($urandom_range(0, 2)) begin
            put($urandom_range(0, 1) ? kvt_pkg::C_SPACE : kvt_pkg::C_TAB);
        end
    endtask

    task automatic put_quoted();
        put(kvt_pkg::C_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 5) == 0) begin
                put(kvt_pkg::C_BSLASH);
                put(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 1) == 0) begin
                put(word_char());
            end else begin
                put(byte_but(kvt_pkg::C_QUOTE, kvt_pkg::C_BSLASH));
            end
        end
        put(kvt_pkg::C_QUOTE);
    endtask

    task automatic put_value_and_end();
        put_blanks();
        if ($urandom_range(0, 2) == 0) begin
            put_quoted();
        end else begin
            repeat ($urandom_range(0, 8)) put(value_char());
        end
        case ($urandom_range(0, 5))
            0: put(kvt_pkg::C_SPACE);
            1: put(kvt_pkg::C_TAB);
            2: put(kvt_pkg::C_CR);
            3: put(kvt_pkg::C_HASH);
            4: begin
                put(kvt_pkg::C_CR);
                put(kvt_pkg::C_LF);
            end
            default: put(kvt_pkg::C_LF);
        endcase
    endtask

    task automatic gen_pair(input bit quoted);
        if (quoted) begin
            put_quoted();
        end else begin
            repeat ($urandom_range(1, 8)) put(word_char());
            if ($urandom_range(0, 7) == 0) begin
                put(kvt_pkg::C_LF);
                repeat ($urandom_range(1, 4)) put(word_char());
            end
        end
        put_blanks();
        put(kvt_pkg::C_EQUAL);
        put_value_and_end();
    endtask

    task automatic gen_section();
        int len;
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
        put(kvt_pkg::C_LBRACK);
        repeat (len) begin
            put(($urandom_range(0, 1) == 0) ? word_char() :
                byte_but(kvt_pkg::C_RBRACK, kvt_pkg::C_RBRACK));
        end
        put(kvt_pkg::C_RBRACK);
        if ($urandom_range(0, 1) == 0) put(kvt_pkg::C_LF);
    endtask

    task automatic gen_comment();
        put(kvt_pkg::C_HASH);
        repeat ($urandom_range(0, 10)) put(byte_but(kvt_pkg::C_LF, kvt_pkg::C_LF));
        put(kvt_pkg::C_LF);
    endtask

    task automatic gen_stop_word();
        string w;
        case ($urandom_range(0, 7))
            0:       w = "ERROR";
            1:       w = "error";
            2:       w = "EOF";
            3:       w = "eof";
            4:       w = "ERRORS";
            5:       w = "Erro";
            6:       w = "EO";
            default: w = "EofX";
        endcase
        for (int i = 0; i < w.len(); i++) put(w[i]);
        repeat ($urandom_range(0, 3)) put(word_char());
        put(kvt_pkg::C_LF);
        repeat ($urandom_range(0, 5)) put(8'($urandom_range(0, 255)));
        flush_text();
        if (halted_p && $urandom_range(0, 3) != 0) send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_random_text();
        int last_hold;
        int pick;
        last_hold = live_cnt;
        while (sent_cnt < 450) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                gen_pair(1'b0);
            end else if (pick < 45) begin
                gen_pair(1'b1);
            end else if (pick < 55) begin
                gen_section();
            end else if (pick < 62) begin
                gen_comment();
            end else if (pick < 67) begin
                put(kvt_pkg::C_EQUAL);
                put_value_and_end();
            end else if (pick < 73) begin
                gen_stop_word();
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
                flush_text();
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                put(($urandom_range(0, 1) == 0) ? kvt_pkg::C_LF : kvt_pkg::C_SPACE);
            end
            flush_text();
            if (live_cnt - last_hold >= 90) begin
                hold_until_drained();
                last_hold = live_cnt;
            end
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------ run

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        restart_parser();

        test_plain_pairs();
        test_quoted();
        test_sections();
        test_long_section();
        test_key_newline();
        test_stops();
        test_finish_states();
        test_byte_extremes();
        test_random_text();

        in_valid <= 1'b0;
        while (token_q.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);

        $display("run covered %0d input transfers (%0d parsed) and %0d output transfers",
                 sent_cnt, live_cnt, rx_cnt);
        $display("stops taken: %0d, finishes: %0d, mismatches: %0d",
                 stop_cnt, fin_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/kvt_pkg.sv
hdl/kvt_dp.sv
hdl/kvt_ctrl.sv
hdl/key_value_text_tokenizer_core.sv
hdl/kvt_checker.sv
dv/tb.sv
